// ===== sv/kts_pkg.sv =====
// Shared widths, codes and defaults for the keyed table with sorted order.
package kts_pkg;

   // Field widths fixed by the channel format
   localparam int REQ_W    = 2;
   localparam int KEY_W    = 32;
   localparam int QTY_W    = 32;
   localparam int STATUS_W = 3;

   // Default table depth
   localparam int MAX_ENTRIES_DEF = 64;

   // Saturation bounds for quantity updates
   localparam logic [QTY_W-1:0] QTY_MAX = {1'b0, {(QTY_W-1){1'b1}}};
   localparam logic [QTY_W-1:0] QTY_MIN = {1'b1, {(QTY_W-1){1'b0}}};

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_SEARCH = 2'd1,
      REQ_UPDATE = 2'd2,
      REQ_LIST   = 2'd3
   } req_code_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_DUPLICATE = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_EMPTY     = 3'd4
   } status_code_type;

endpackage

// ===== sv/kts_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface kts_req_if;
   logic                            valid;
   logic                            ready;
   logic [kts_pkg::REQ_W-1:0]       req_type;
   logic signed [kts_pkg::KEY_W-1:0] part_key;
   logic signed [kts_pkg::QTY_W-1:0] amount;

   modport source (output valid, req_type, part_key, amount, input ready);
   modport sink   (input valid, req_type, part_key, amount, output ready);
endinterface

interface kts_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [kts_pkg::STATUS_W-1:0]     status;
   logic signed [kts_pkg::KEY_W-1:0] out_key;
   logic signed [kts_pkg::QTY_W-1:0] out_quantity;
   logic                             last;

   modport source (output valid, status, out_key, out_quantity, last, input ready);
   modport sink   (input valid, status, out_key, out_quantity, last, output ready);
endinterface

// ===== sv/kts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable; hold read data unless a read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/keyed_table_with_sorted_order.sv =====
// Keyed table with a sorted slot index, run by a small sequencer over three RAMs.
// Search scans the stored keys in slot order; update and duplicate insert do the same.
// Insert: key scan plus top-down index shift; a full table is answered without a scan.
// List: per entry, an order read, then a key/quantity read, then the output load.
// One request at a time; the response register lets the next request be taken early.
// Synchronous reset empties the table; RAM contents are not cleared and need no sweep.
module keyed_table_with_sorted_order #(
   parameter int MAX_ENTRIES = kts_pkg::MAX_ENTRIES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   kts_req_if.sink   req_chan,
   kts_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_QTY,
      ST_INS_WR,
      ST_SHIFT,
      ST_INS_FIN,
      ST_SEND,
      ST_L_ORD,
      ST_L_KEY,
      ST_L_OUT
   } state_type;

   // Sequencer state
   state_type                  state_ff, state_in;
   kts_pkg::req_code_type      op_ff, op_in;
   logic [kts_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [kts_pkg::QTY_W-1:0]  amt_ff, amt_in;
   logic [CNT_W-1:0]           count_ff, count_in;

   // Key scan pipeline
   logic [CNT_W-1:0]           scan_ff, scan_in;
   logic                       pend_ff, pend_in;
   logic [IDX_W-1:0]           pend_slot_ff, pend_slot_in;
   logic [IDX_W-1:0]           slot_ff, slot_in;

   // Index shift pipeline
   logic [CNT_W-1:0]           sh_rd_ff, sh_rd_in;
   logic                       s1_ff, s1_in;
   logic [IDX_W-1:0]           s1_addr_ff, s1_addr_in;
   logic                       s2_ff, s2_in;
   logic [IDX_W-1:0]           s2_addr_ff, s2_addr_in;
   logic [IDX_W-1:0]           s2_ord_ff, s2_ord_in;
   logic [IDX_W-1:0]           pos_ff, pos_in;

   // List walk
   logic [CNT_W-1:0]           list_ff, list_in;
   logic                       list_last;

   // Staged single result
   kts_pkg::status_code_type   res_status_ff, res_status_in;
   logic [kts_pkg::KEY_W-1:0]  res_key_ff, res_key_in;
   logic [kts_pkg::QTY_W-1:0]  res_qty_ff, res_qty_in;

   // Response register
   logic                       rsp_valid_ff, rsp_valid_in;
   kts_pkg::status_code_type   rsp_status_ff, rsp_status_in;
   logic [kts_pkg::KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [kts_pkg::QTY_W-1:0]  rsp_qty_ff, rsp_qty_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_free;

   // RAM ports
   logic                       key_we, key_re;
   logic [IDX_W-1:0]           key_wa, key_ra;
   logic [kts_pkg::KEY_W-1:0]  key_wd, key_rd;
   logic                       qty_we, qty_re;
   logic [IDX_W-1:0]           qty_wa, qty_ra;
   logic [kts_pkg::QTY_W-1:0]  qty_wd, qty_rd;
   logic                       ord_we, ord_re;
   logic [IDX_W-1:0]           ord_wa, ord_ra;
   logic [IDX_W-1:0]           ord_wd, ord_rd;

   // Saturating add
   logic [kts_pkg::QTY_W:0]    sum_wide;
   logic [kts_pkg::QTY_W-1:0]  sum_sat;

   kts_ram #(.WIDTH(kts_pkg::KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (key_wd),
      .rd_en   (key_re),
      .rd_addr (key_ra),
      .rd_data (key_rd)
   );

   kts_ram #(.WIDTH(kts_pkg::QTY_W), .DEPTH(MAX_ENTRIES)) u_qty_ram (
      .clock   (clock),
      .wr_en   (qty_we),
      .wr_addr (qty_wa),
      .wr_data (qty_wd),
      .rd_en   (qty_re),
      .rd_addr (qty_ra),
      .rd_data (qty_rd)
   );

   kts_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_ord_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_wa),
      .wr_data (ord_wd),
      .rd_en   (ord_re),
      .rd_addr (ord_ra),
      .rd_data (ord_rd)
   );

   // Add the change to the stored quantity and clamp on overflow
   always_comb begin
      sum_wide = {qty_rd[kts_pkg::QTY_W-1], qty_rd} + {amt_ff[kts_pkg::QTY_W-1], amt_ff};
      if (sum_wide[kts_pkg::QTY_W] != sum_wide[kts_pkg::QTY_W-1]) begin
         sum_sat = sum_wide[kts_pkg::QTY_W] ? kts_pkg::QTY_MIN : kts_pkg::QTY_MAX;
      end else begin
         sum_sat = sum_wide[kts_pkg::QTY_W-1:0];
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign list_last = ((list_ff + CNT_ONE) == count_ff);

   // Sequencer next-state and datapath control
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      amt_in        = amt_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_slot_in  = pend_slot_ff;
      slot_in       = slot_ff;
      sh_rd_in      = sh_rd_ff;
      s1_in         = s1_ff;
      s1_addr_in    = s1_addr_ff;
      s2_in         = s2_ff;
      s2_addr_in    = s2_addr_ff;
      s2_ord_in     = s2_ord_ff;
      pos_in        = pos_ff;
      list_in       = list_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_qty_in    = res_qty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_last_in   = rsp_last_ff;

      key_we = 1'b0;  key_wa = '0;  key_wd = '0;
      key_re = 1'b0;  key_ra = '0;
      qty_we = 1'b0;  qty_wa = '0;  qty_wd = '0;
      qty_re = 1'b0;  qty_ra = '0;
      ord_we = 1'b0;  ord_wa = '0;  ord_wd = '0;
      ord_re = 1'b0;  ord_ra = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // Take a request word and branch on its code
            if (req_chan.valid) begin
               op_in   = kts_pkg::req_code_type'(req_chan.req_type);
               key_in  = req_chan.part_key;
               amt_in  = req_chan.amount;
               scan_in = '0;
               pend_in = 1'b0;
               unique case (kts_pkg::req_code_type'(req_chan.req_type))
                  kts_pkg::REQ_INSERT: begin
                     if (count_ff == MAX_CNT) begin
                        res_status_in = kts_pkg::STAT_FULL;
                        res_key_in    = req_chan.part_key;
                        res_qty_in    = '0;
                        state_in      = ST_SEND;
                     end else begin
                        state_in = ST_FIND;
                     end
                  end
                  kts_pkg::REQ_SEARCH,
                  kts_pkg::REQ_UPDATE: begin
                     state_in = ST_FIND;
                  end
                  kts_pkg::REQ_LIST: begin
                     if (count_ff == '0) begin
                        res_status_in = kts_pkg::STAT_EMPTY;
                        res_key_in    = '0;
                        res_qty_in    = '0;
                        state_in      = ST_SEND;
                     end else begin
                        list_in  = '0;
                        state_in = ST_L_ORD;
                     end
                  end
               endcase
            end
         end

         ST_FIND: begin
            // Issue the next key read
            if (scan_ff < count_ff) begin
               key_re       = 1'b1;
               key_ra       = scan_ff[IDX_W-1:0];
               pend_in      = 1'b1;
               pend_slot_in = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + CNT_ONE;
            end else begin
               pend_in = 1'b0;
            end
            // Compare the key that came back
            if (pend_ff && (key_rd == key_ff)) begin
               qty_re   = 1'b1;
               qty_ra   = pend_slot_ff;
               slot_in  = pend_slot_ff;
               state_in = ST_QTY;
            end else if (!pend_ff && (scan_ff >= count_ff)) begin
               if (op_ff == kts_pkg::REQ_INSERT) begin
                  state_in = ST_INS_WR;
               end else begin
                  res_status_in = kts_pkg::STAT_NOT_FOUND;
                  res_key_in    = key_ff;
                  res_qty_in    = '0;
                  state_in      = ST_SEND;
               end
            end
         end

         ST_QTY: begin
            // Report the found entry, updating its quantity if asked
            res_key_in = key_ff;
            unique case (op_ff)
               kts_pkg::REQ_INSERT: begin
                  res_status_in = kts_pkg::STAT_DUPLICATE;
                  res_qty_in    = qty_rd;
               end
               kts_pkg::REQ_UPDATE: begin
                  qty_we        = 1'b1;
                  qty_wa        = slot_ff;
                  qty_wd        = sum_sat;
                  res_status_in = kts_pkg::STAT_OK;
                  res_qty_in    = sum_sat;
               end
               kts_pkg::REQ_SEARCH,
               kts_pkg::REQ_LIST: begin
                  res_status_in = kts_pkg::STAT_OK;
                  res_qty_in    = qty_rd;
               end
            endcase
            state_in = ST_SEND;
         end

         ST_INS_WR: begin
            // Append the new entry and start the index shift from the top
            key_we   = 1'b1;
            key_wa   = count_ff[IDX_W-1:0];
            key_wd   = key_ff;
            qty_we   = 1'b1;
            qty_wa   = count_ff[IDX_W-1:0];
            qty_wd   = amt_ff;
            sh_rd_in = count_ff;
            s1_in    = 1'b0;
            s2_in    = 1'b0;
            if (count_ff == '0) begin
               pos_in   = '0;
               state_in = ST_INS_FIN;
            end else begin
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // Stage 0: read the next lower index position
            if (sh_rd_ff != '0) begin
               ord_re     = 1'b1;
               ord_ra     = IDX_W'(sh_rd_ff - CNT_ONE);
               s1_in      = 1'b1;
               s1_addr_in = IDX_W'(sh_rd_ff - CNT_ONE);
               sh_rd_in   = sh_rd_ff - CNT_ONE;
            end else begin
               s1_in = 1'b0;
            end
            // Stage 1: read the key of that slot
            if (s1_ff) begin
               key_re     = 1'b1;
               key_ra     = ord_rd;
               s2_in      = 1'b1;
               s2_addr_in = s1_addr_ff;
               s2_ord_in  = ord_rd;
            end else begin
               s2_in = 1'b0;
            end
            // Stage 2: move a larger key up one place, or stop below it
            if (s2_ff) begin
               if ($signed(key_ff) < $signed(key_rd)) begin
                  ord_we = 1'b1;
                  ord_wa = s2_addr_ff + IDX_ONE;
                  ord_wd = s2_ord_ff;
                  if (s2_addr_ff == '0) begin
                     pos_in   = '0;
                     state_in = ST_INS_FIN;
                  end
               end else begin
                  pos_in   = s2_addr_ff + IDX_ONE;
                  state_in = ST_INS_FIN;
               end
            end
         end

         ST_INS_FIN: begin
            // Drop the new slot into the gap and count it
            ord_we        = 1'b1;
            ord_wa        = pos_ff;
            ord_wd        = count_ff[IDX_W-1:0];
            count_in      = count_ff + CNT_ONE;
            res_status_in = kts_pkg::STAT_OK;
            res_key_in    = key_ff;
            res_qty_in    = amt_ff;
            state_in      = ST_SEND;
         end

         ST_SEND: begin
            // Hand the staged result to the response register
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = res_key_ff;
               rsp_qty_in    = res_qty_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_L_ORD: begin
            ord_re   = 1'b1;
            ord_ra   = list_ff[IDX_W-1:0];
            state_in = ST_L_KEY;
         end

         ST_L_KEY: begin
            key_re   = 1'b1;
            key_ra   = ord_rd;
            qty_re   = 1'b1;
            qty_ra   = ord_rd;
            state_in = ST_L_OUT;
         end

         ST_L_OUT: begin
            // Emit one entry in key order; hold while the response is stalled
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = kts_pkg::STAT_OK;
               rsp_key_in    = key_rd;
               rsp_qty_in    = qty_rd;
               rsp_last_in   = list_last;
               list_in       = list_ff + CNT_ONE;
               state_in      = list_last ? ST_IDLE : ST_L_ORD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      amt_ff        <= amt_in;
      scan_ff       <= scan_in;
      pend_slot_ff  <= pend_slot_in;
      slot_ff       <= slot_in;
      sh_rd_ff      <= sh_rd_in;
      s1_addr_ff    <= s1_addr_in;
      s2_addr_ff    <= s2_addr_in;
      s2_ord_ff     <= s2_ord_in;
      pos_ff        <= pos_in;
      list_ff       <= list_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_qty_ff    <= res_qty_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_key      = rsp_key_ff;
   assign rsp_chan.out_quantity = rsp_qty_ff;
   assign rsp_chan.last         = rsp_last_ff;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the keyed table: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module tb_top;
   import kts_pkg::*;

   localparam int TABLE_DEPTH    = MAX_ENTRIES_DEF;
   localparam int KEY_POOL_PCT   = 50;
   localparam int PHASE_COUNT    = 4;
   localparam int PHASE_WORDS    = 118;
   localparam int MAX_GAP        = 20;
   localparam int SETTLE_CYCLES  = 256;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   typedef struct {
      req_code_type              op;
      logic signed [KEY_W-1:0]   key;
      logic signed [QTY_W-1:0]   amt;
   } req_word_t;

   typedef struct {
      status_code_type           status;
      logic signed [KEY_W-1:0]   key;
      logic signed [QTY_W-1:0]   qty;
      logic                      last;
   } rsp_word_t;

   typedef struct {
      req_code_type              op;
      logic signed [KEY_W-1:0]   key;
      logic signed [QTY_W-1:0]   amt;
      bit                        pinned;
      status_code_type           status;
      logic signed [KEY_W-1:0]   out_key;
      logic signed [QTY_W-1:0]   out_qty;
   } directed_row_t;

   logic clock;
   logic reset;

   kts_req_if req_chan ();
   kts_rsp_if rsp_chan ();

   keyed_table_with_sorted_order #(
      .MAX_ENTRIES (TABLE_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the table kept by the predictor
   logic signed [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
   logic signed [QTY_W-1:0] shadow_qtys [TABLE_DEPTH];
   int                      shadow_order [TABLE_DEPTH];
   int                      shadow_entries;

   rsp_word_t expected_results [$];
   int        fail_count;
   int        quiet_cycles;
   int        stall_pct;

   // Directed words: pinned rows override the predicted result with their typed one
   directed_row_t directed_rows [19] = '{
      '{REQ_LIST,   32'sd0,       32'sd0,       1'b1, STAT_EMPTY,     32'sd0,   32'sd0},
      '{REQ_SEARCH, 32'sd5,       32'sd0,       1'b1, STAT_NOT_FOUND, 32'sd5,   32'sd0},
      '{REQ_UPDATE, 32'sd7,       32'sd3,       1'b1, STAT_NOT_FOUND, 32'sd7,   32'sd0},
      '{REQ_INSERT, KEY_MAX,      KEY_MAX,      1'b1, STAT_OK,        KEY_MAX,  KEY_MAX},
      '{REQ_INSERT, KEY_MIN,      KEY_MIN,      1'b1, STAT_OK,        KEY_MIN,  KEY_MIN},
      '{REQ_INSERT, 32'sd0,       -32'sd1,      1'b1, STAT_OK,        32'sd0,   -32'sd1},
      '{REQ_INSERT, -32'sd1,      32'sd100,     1'b1, STAT_OK,        -32'sd1,  32'sd100},
      '{REQ_INSERT, 32'sd100,     32'sd0,       1'b1, STAT_OK,        32'sd100, 32'sd0},
      '{REQ_INSERT, 32'sd0,       32'sd5,       1'b1, STAT_DUPLICATE, 32'sd0,   -32'sd1},
      '{REQ_UPDATE, KEY_MAX,      32'sd1,       1'b1, STAT_OK,        KEY_MAX,  KEY_MAX},
      '{REQ_UPDATE, KEY_MIN,      -32'sd1,      1'b1, STAT_OK,        KEY_MIN,  KEY_MIN},
      '{REQ_UPDATE, -32'sd1,      KEY_MAX,      1'b1, STAT_OK,        -32'sd1,  KEY_MAX},
      '{REQ_UPDATE, -32'sd1,      KEY_MIN,      1'b1, STAT_OK,        -32'sd1,  -32'sd1},
      '{REQ_SEARCH, 32'sd100,     32'sd7,       1'b1, STAT_OK,        32'sd100, 32'sd0},
      '{REQ_LIST,   32'sd9,       32'sd9,       1'b0, STAT_OK,        32'sd0,   32'sd0},
      '{REQ_INSERT, 32'sd50,      32'shAAAAAAAA, 1'b0, STAT_OK,       32'sd0,   32'sd0},
      '{REQ_UPDATE, 32'sd50,      32'sh55555555, 1'b0, STAT_OK,       32'sd0,   32'sd0},
      '{REQ_SEARCH, 32'sh55555555, 32'sd0,      1'b1, STAT_NOT_FOUND, 32'sh55555555, 32'sd0},
      '{REQ_LIST,   32'sd0,       32'sd0,       1'b0, STAT_OK,        32'sd0,   32'sd0}
   };

   // Free-running clock, 4 ns period
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Queue one expected result word
   function automatic void push_result(input status_code_type st,
                                       input logic signed [KEY_W-1:0] key,
                                       input logic signed [QTY_W-1:0] qty,
                                       input logic last);
      rsp_word_t w;
      w.status = st;
      w.key    = key;
      w.qty    = qty;
      w.last   = last;
      expected_results.push_back(w);
   endfunction

   // Apply one accepted request to the shadow table and queue its results
   function automatic void predict_table_op(input req_word_t rq);
      int                      slot;
      int                      pos;
      int                      j;
      logic signed [QTY_W:0]   sum;
      slot = -1;
      for (j = 0; j < shadow_entries; j++) begin
         if (slot < 0 && shadow_keys[j] == rq.key) slot = j;
      end
      case (rq.op)
         REQ_INSERT: begin
            if (shadow_entries >= TABLE_DEPTH) begin
               push_result(STAT_FULL, rq.key, '0, 1'b1);
            end else if (slot >= 0) begin
               push_result(STAT_DUPLICATE, rq.key, shadow_qtys[slot], 1'b1);
            end else begin
               shadow_keys[shadow_entries] = rq.key;
               shadow_qtys[shadow_entries] = rq.amt;
               // find first position holding a larger key, then shift the tail up
               pos = 0;
               while (pos < shadow_entries && shadow_keys[shadow_order[pos]] < rq.key)
                  pos++;
               for (j = shadow_entries; j > pos; j--)
                  shadow_order[j] = shadow_order[j-1];
               shadow_order[pos] = shadow_entries;
               shadow_entries++;
               push_result(STAT_OK, rq.key, rq.amt, 1'b1);
            end
         end
         REQ_SEARCH, REQ_UPDATE: begin
            if (slot < 0) begin
               push_result(STAT_NOT_FOUND, rq.key, '0, 1'b1);
            end else begin
               if (rq.op == REQ_UPDATE) begin
                  // saturate when the carry disagrees with the sign
                  sum = shadow_qtys[slot] + rq.amt;
                  if (sum[QTY_W] != sum[QTY_W-1])
                     shadow_qtys[slot] = sum[QTY_W] ? QTY_MIN : QTY_MAX;
                  else
                     shadow_qtys[slot] = sum[QTY_W-1:0];
               end
               push_result(STAT_OK, rq.key, shadow_qtys[slot], 1'b1);
            end
         end
         default: begin
            if (shadow_entries == 0) begin
               push_result(STAT_EMPTY, '0, '0, 1'b1);
            end else begin
               for (j = 0; j < shadow_entries; j++)
                  push_result(STAT_OK, shadow_keys[shadow_order[j]],
                              shadow_qtys[shadow_order[j]], j == shadow_entries - 1);
            end
         end
      endcase
   endfunction

   // Pick a key: often one already stored, sometimes an extreme, else random
   function automatic logic signed [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (shadow_entries > 0 && roll < KEY_POOL_PCT)
         return shadow_keys[$urandom_range(0, shadow_entries - 1)];
      if (roll < KEY_POOL_PCT + 15) begin
         case ($urandom_range(0, 4))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            3:       return -32'sd1;
            default: return 32'sd100;
         endcase
      end
      return $urandom;
   endfunction

   // Pick an amount: extremes, small signed values or full range
   function automatic logic signed [QTY_W-1:0] pick_amount();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return KEY_MAX;
      if (roll < 20) return KEY_MIN;
      if (roll < 45) return $signed($urandom_range(0, 200)) - 100;
      return $urandom;
   endfunction

   function automatic req_word_t random_request();
      req_word_t rq;
      int        roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)      rq.op = REQ_INSERT;
      else if (roll < 60) rq.op = REQ_SEARCH;
      else if (roll < 90) rq.op = REQ_UPDATE;
      else                rq.op = REQ_LIST;
      rq.key = pick_key();
      rq.amt = pick_amount();
      return rq;
   endfunction

   // Present one word after a random gap and hold it until accepted
   task automatic send_word(input req_word_t rq, input int idle_pct);
      int gap;
      gap = 0;
      while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= rq.op;
      req_chan.part_key <= rq.key;
      req_chan.amount   <= rq.amt;
      do @(posedge clock); while (!req_chan.ready);
      predict_table_op(rq);
   endtask

   // Drop valid and hold off until every expected word has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", field, want, got);
         fail_count++;
      end
   endtask

   // Randomly stall the result channel
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Check result words in order and watch for a stalled channel
   always @(posedge clock) begin
      rsp_word_t exp_word;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result word: status %0d key %h quantity %h last %b",
                      rsp_chan.status, rsp_chan.out_key, rsp_chan.out_quantity,
                      rsp_chan.last);
               fail_count++;
            end else begin
               exp_word = expected_results.pop_front();
               compare_field("status", 32'(exp_word.status), 32'(rsp_chan.status));
               compare_field("out_key", exp_word.key, rsp_chan.out_key);
               compare_field("out_quantity", exp_word.qty, rsp_chan.out_quantity);
               compare_field("last", 32'(exp_word.last), 32'(rsp_chan.last));
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed table, then four idling phases
   initial begin
      int        phase_idle [PHASE_COUNT];
      int        phase_stall [PHASE_COUNT];
      req_word_t rq;
      rsp_word_t pin;
      int        p;
      int        n;
      phase_idle  = '{0, 50, 0, 29};
      phase_stall = '{0, 0, 50, 29};
      fail_count        = 0;
      quiet_cycles      = 0;
      stall_pct         = 0;
      shadow_entries    = 0;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.req_type = REQ_INSERT;
      req_chan.part_key = '0;
      req_chan.amount   = '0;
      rsp_chan.ready    = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table with no idling
      for (n = 0; n < $size(directed_rows); n++) begin
         rq.op  = directed_rows[n].op;
         rq.key = directed_rows[n].key;
         rq.amt = directed_rows[n].amt;
         send_word(rq, 0);
         if (directed_rows[n].pinned) begin
            pin.status = directed_rows[n].status;
            pin.key    = directed_rows[n].out_key;
            pin.qty    = directed_rows[n].out_qty;
            pin.last   = 1'b1;
            expected_results[expected_results.size() - 1] = pin;
         end
      end

      // random phases; fill the table before the last one so it runs full
      for (p = 0; p < PHASE_COUNT; p++) begin
         wait_for_results();
         stall_pct = phase_stall[p];
         if (p == PHASE_COUNT - 1) begin
            while (shadow_entries < TABLE_DEPTH) begin
               rq.op  = REQ_INSERT;
               rq.key = $urandom;
               rq.amt = pick_amount();
               send_word(rq, phase_idle[p]);
            end
         end
         for (n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 99) < 3) wait_for_results();
            send_word(random_request(), phase_idle[p]);
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
